// ----- hw/rtl/ssmd_pkg.sv -----
package ssmd_pkg;

    localparam int DIGITS   = 3;
    localparam int SEGMENTS = 7;
    localparam int PIN_W    = 10;
    localparam int CHAR_W   = 8;
    localparam int CMD_W    = 2;
    localparam int BYTE_W   = 8;
    localparam int SCAN_W   = 2;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK = 2'd0,
        CMD_TEXT = 2'd1,
        CMD_RAW  = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ORIENTATION = 1'b0,
        REG_PIN_OFFSET  = 1'b1
    } t_reg_idx;

    // Segment s moves to segment ROT_MAP[s] when the display is rotated
    localparam logic [2:0] ROT_MAP [SEGMENTS] = '{3'd3, 3'd4, 3'd5, 3'd0, 3'd1, 3'd2, 3'd6};

    // Digit sink pin per scan position
    localparam logic [PIN_W-1:0] SINK_BIT [DIGITS] = '{10'd4, 10'd2, 10'd1};

    // Result of one lane: segment pins 9..3 as bits 6..0, and a NUL flag
    typedef struct packed {
        logic [SEGMENTS-1:0] seg_pins;
        logic                is_nul;
    } t_lane_res;

    function automatic logic [SEGMENTS-1:0] glyph_of(input logic [CHAR_W-1:0] code);
        logic [SEGMENTS-1:0] g;
        case (code)
            8'h30:   g = 7'h3f;  // '0'
            8'h31:   g = 7'h06;
            8'h32:   g = 7'h5b;
            8'h33:   g = 7'h4f;
            8'h34:   g = 7'h66;
            8'h35:   g = 7'h6d;
            8'h36:   g = 7'h7d;
            8'h37:   g = 7'h07;
            8'h38:   g = 7'h7f;
            8'h39:   g = 7'h6f;
            8'h61:   g = 7'h77;  // 'a'
            8'h62:   g = 7'h7c;
            8'h63:   g = 7'h39;
            8'h64:   g = 7'h5e;
            8'h65:   g = 7'h79;
            8'h66:   g = 7'h71;
            8'h5f:   g = 7'h08;  // underscore
            8'h2a:   g = 7'h63;  // asterisk
            8'h27:   g = 7'h20;  // single quote
            8'h22:   g = 7'h0a;  // double quote
            default: g = 7'h00;  // space and unknown codes show blank
        endcase
        return g;
    endfunction

    // Segment s lands on pin 9-t, i.e. bit 6-t of the 7-bit segment pin field
    function automatic logic [SEGMENTS-1:0] seg_to_pins(input logic [SEGMENTS-1:0] mask,
                                                       input logic rotated);
        logic [SEGMENTS-1:0] p;
        logic [2:0]          t;
        p = '0;
        for (int s = 0; s < SEGMENTS; s++) begin
            t = rotated ? ROT_MAP[s] : 3'(s);
            if (mask[s]) begin
                p[3'(SEGMENTS - 1) - t] = 1'b1;
            end
        end
        return p;
    endfunction

endpackage

// ----- hw/rtl/ssmd_if.sv -----
interface ssmd_in_if
    import ssmd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [CHAR_W-1:0] digit_value_0;
    logic [CHAR_W-1:0] digit_value_1;
    logic [CHAR_W-1:0] digit_value_2;

    modport source (output valid, command, digit_value_0, digit_value_1, digit_value_2,
                    input ready);
    modport sink (input valid, command, digit_value_0, digit_value_1, digit_value_2,
                  output ready);
endinterface

interface ssmd_out_if
    import ssmd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [PIN_W-1:0]  pin_pattern;
    logic [BYTE_W-1:0] port_low_value;
    logic [BYTE_W-1:0] port_high_value;
    logic [BYTE_W-1:0] port_low_enable;
    logic [BYTE_W-1:0] port_high_enable;

    modport source (output valid, pin_pattern, port_low_value, port_high_value,
                    port_low_enable, port_high_enable, input ready);
    modport sink (input valid, pin_pattern, port_low_value, port_high_value,
                  port_low_enable, port_high_enable, output ready);
endinterface

interface ssmd_cfg_if
    import ssmd_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic                 data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/ssmd_lane.sv -----
module ssmd_lane
    import ssmd_pkg::*;
(
    input  logic [CHAR_W-1:0] i_value,
    input  logic              i_raw,
    input  logic              i_rotated,
    output t_lane_res         o_res
);

    logic [SEGMENTS-1:0] mask;

    always_comb begin
        // drop bit 7 of a raw mask
        mask = i_raw ? i_value[SEGMENTS-1:0] : glyph_of(i_value);
        o_res.seg_pins = seg_to_pins(mask, i_rotated);
        o_res.is_nul   = (i_value == '0);
    end

endmodule

// ----- hw/rtl/ssmd_merge.sv -----
module ssmd_merge
    import ssmd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic               i_text,
    input  logic               i_rotated,
    input  t_lane_res          i_lane [DIGITS],
    input  logic               i_tick,
    input  logic               i_offset_sel,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [PIN_W-1:0]   o_pin_pattern,
    output logic [BYTE_W-1:0]  o_port_low_value,
    output logic [BYTE_W-1:0]  o_port_high_value,
    output logic [BYTE_W-1:0]  o_port_low_enable,
    output logic [BYTE_W-1:0]  o_port_high_enable,
    output logic               o_slot_free
);

    logic [PIN_W-1:0]  r_pat [DIGITS];
    logic [PIN_W-1:0]  n_pat [DIGITS];
    logic [SCAN_W-1:0] r_scan;
    logic [SCAN_W-1:0] n_scan;
    logic              r_valid;
    logic [PIN_W-1:0]  r_pin;
    logic [BYTE_W-1:0] r_lo_val;
    logic [BYTE_W-1:0] r_hi_val;
    logic [BYTE_W-1:0] r_lo_en;
    logic [BYTE_W-1:0] r_hi_en;

    logic [SEGMENTS-1:0] seg [DIGITS];
    logic                ended;
    logic [PIN_W-1:0]    cur;

    assign o_slot_free = !r_valid || i_out_ready;

    always_comb begin
        // a NUL character in a text item blanks itself and every later digit
        ended = 1'b0;
        for (int i = 0; i < DIGITS; i++) begin
            ended  = ended || (i_text && i_lane[i].is_nul);
            seg[i] = ended ? '0 : i_lane[i].seg_pins;
        end
        for (int i = 0; i < DIGITS; i++) begin
            n_pat[i] = {(i_rotated ? seg[DIGITS-1-i] : seg[i]), 3'b000} | SINK_BIT[i];
        end

        case (r_scan)
            2'd1:    cur = r_pat[1];
            2'd2:    cur = r_pat[2];
            default: cur = r_pat[0];
        endcase
        case (r_scan)
            2'd0:    n_scan = 2'd1;
            2'd1:    n_scan = 2'd2;
            default: n_scan = 2'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIGITS; i++) begin
                r_pat[i] <= SINK_BIT[i];
            end
            r_scan  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_pat <= n_pat;
            end
            if (i_tick) begin
                r_scan  <= n_scan;
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // output payload, held while the item waits
    always_ff @(posedge i_clk) begin
        if (i_tick) begin
            r_pin <= cur;
            if (i_offset_sel) begin
                r_lo_val <= {cur[3:0], 4'h0};
                r_hi_val <= {2'b00, cur[9:4]};
                r_lo_en  <= 8'hf0;
                r_hi_en  <= 8'h3f;
            end else begin
                r_lo_val <= {cur[5:0], 2'b00};
                r_hi_val <= {4'h0, cur[9:6]};
                r_lo_en  <= 8'hfc;
                r_hi_en  <= 8'h0f;
            end
        end
    end

    assign o_out_valid        = r_valid;
    assign o_pin_pattern      = r_pin;
    assign o_port_low_value   = r_lo_val;
    assign o_port_high_value  = r_hi_val;
    assign o_port_low_enable  = r_lo_en;
    assign o_port_high_enable = r_hi_en;

endmodule

// ----- hw/rtl/seven_segment_mux_driver_core.sv -----
// Three-digit multiplexed seven-segment driver.
// A tick item's result is registered and valid in the cycle after acceptance.
// Set items update the stored patterns at acceptance. Throughput: one item per cycle
// while input is taken: when the output register is empty or drained this cycle.
// Reset (synchronous, active low): patterns hold sink bits only, scan at digit 0,
// orientation and pin offset select cleared, no result pending.
module seven_segment_mux_driver_core
    import ssmd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    ssmd_in_if.sink     i_in,
    ssmd_cfg_if.sink    i_cfg,
    ssmd_out_if.source  o_out
);

    logic      r_orientation;
    logic      r_offset_sel;
    logic      slot_free;
    logic      accept;
    logic      tick;
    logic      load;
    logic      raw;
    logic      text;
    t_cmd      cmd;
    t_lane_res lane_res [DIGITS];
    logic [CHAR_W-1:0] lane_val [DIGITS];

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orientation <= 1'b0;
            r_offset_sel  <= 1'b0;
        end else if (i_cfg.valid) begin
            case (t_reg_idx'(i_cfg.index))
                REG_ORIENTATION: r_orientation <= i_cfg.data;
                REG_PIN_OFFSET:  r_offset_sel  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    assign i_in.ready = slot_free;
    assign accept     = i_in.valid && slot_free;
    assign cmd        = t_cmd'(i_in.command);

    always_comb begin
        tick = 1'b0;
        text = 1'b0;
        raw  = 1'b0;
        case (cmd)
            CMD_TICK: tick = accept;
            CMD_TEXT: text = 1'b1;
            CMD_RAW:  raw  = 1'b1;
            default: ;  // unused command code: no effect
        endcase
    end

    assign load = accept && (text || raw);

    assign lane_val[0] = i_in.digit_value_0;
    assign lane_val[1] = i_in.digit_value_1;
    assign lane_val[2] = i_in.digit_value_2;

    for (genvar g = 0; g < DIGITS; g++) begin : g_lane
        ssmd_lane u_lane (
            .i_value   (lane_val[g]),
            .i_raw     (raw),
            .i_rotated (r_orientation),
            .o_res     (lane_res[g])
        );
    end

    ssmd_merge u_merge (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_load             (load),
        .i_text             (text),
        .i_rotated          (r_orientation),
        .i_lane             (lane_res),
        .i_tick             (tick),
        .i_offset_sel       (r_offset_sel),
        .i_out_ready        (o_out.ready),
        .o_out_valid        (o_out.valid),
        .o_pin_pattern      (o_out.pin_pattern),
        .o_port_low_value   (o_out.port_low_value),
        .o_port_high_value  (o_out.port_high_value),
        .o_port_low_enable  (o_out.port_low_enable),
        .o_port_high_enable (o_out.port_high_enable),
        .o_slot_free        (slot_free)
    );

endmodule
